// ===== design/qmc_pkg.sv =====
// Shared types, constants and the step classification for the quadrature move counter.
package qmc_pkg;

    localparam int NUM_MOTORS  = 2;
    localparam int COUNT_WIDTH = 16;
    localparam int MOTOR_AW    = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int SECOND_IDX  = (NUM_MOTORS > 1) ? 1 : 0;

    typedef logic [MOTOR_AW-1:0] motor_idx_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [1:0] {
        KIND_EDGE    = 2'd0,
        KIND_TICK    = 2'd1,
        KIND_MOVE    = 2'd2,
        KIND_COLLECT = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2,
        DIR_SKIP = 2'd3
    } dir_t;

    // Per-motor record held in the state RAM.
    typedef struct packed {
        logic [1:0]  code;
        dir_t        dir;
        logic [31:0] steps;
        logic [15:0] target;
    } motor_rec_t;

    localparam int REC_W = $bits(motor_rec_t);

    typedef struct packed {
        logic       found;
        motor_idx_t idx;
    } hit_t;

    // Classifies the move from the previous A/B code to the new one.
    function automatic dir_t step_class(input logic [1:0] prev, input logic [1:0] code);
        dir_t d;
        unique case ({prev, code})
            4'h0: d = DIR_NONE;
            4'h1: d = DIR_REV;
            4'h2: d = DIR_FWD;
            4'h3: d = DIR_SKIP;
            4'h4: d = DIR_FWD;
            4'h5: d = DIR_NONE;
            4'h6: d = DIR_SKIP;
            4'h7: d = DIR_REV;
            4'h8: d = DIR_REV;
            4'h9: d = DIR_SKIP;
            4'hA: d = DIR_NONE;
            4'hB: d = DIR_FWD;
            4'hC: d = DIR_SKIP;
            4'hD: d = DIR_FWD;
            4'hE: d = DIR_REV;
            4'hF: d = DIR_NONE;
            default: d = DIR_NONE;
        endcase
        return d;
    endfunction

    // Lowest motor whose move has finished and has not yet been reported.
    function automatic hit_t find_done(input logic [NUM_MOTORS-1:0] rep,
                                       input logic [NUM_MOTORS-1:0] zer);
        hit_t h;
        h = '0;
        for (int i = NUM_MOTORS - 1; i >= 0; i--)
        begin
            if (!rep[i] && zer[i])
            begin
                h.found = 1'b1;
                h.idx   = MOTOR_AW'(i);
            end
        end
        return h;
    endfunction

endpackage

// ===== design/qmc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module qmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/quadrature_move_counter.sv =====
// Quadrature move counter top level: per-motor record RAM, flag registers and result register.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+-------------------------------------------------------
//   input   | in_valid / in_ready  | kind, motor, line_a, line_b, move_steps, speed_target
//   output  | out_valid/ out_ready | out_motor, direction_code, move_done, found, steps_left,
//           |                      | count_first, count_second, stop_first, stop_second,
//           |                      | target_now
//
// One transaction per cycle is sustained while out_ready is held high; a result passes through the
// second stage and then the result register once its input transaction is accepted.
// The first stage reads the motor record from the RAM, the second modifies it, writes it
// back and loads the result register; a write made in the same cycle as a read is forwarded.
// Reset returns the flags to their idle state and marks every RAM entry as unwritten, so it
// reads as zero; no clearing pass is needed.
// A stalled result register holds the second stage, which in turn holds the input.
module quadrature_move_counter
    import qmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  kind,
    input  logic        motor,
    input  logic        line_a,
    input  logic        line_b,
    input  logic [31:0] move_steps,
    input  logic [15:0] speed_target,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        out_motor,
    output logic [1:0]  direction_code,
    output logic        move_done,
    output logic        found,
    output logic [31:0] steps_left,
    output logic [15:0] count_first,
    output logic [15:0] count_second,
    output logic        stop_first,
    output logic        stop_second,
    output logic [15:0] target_now
);

    // Handshake and stage control
    logic in_fire;
    logic s1_adv;

    // Second stage
    logic        s1_valid_reg;
    kind_t       s1_kind_reg;
    logic        s1_motor_reg;
    logic        s1_ok_reg;
    motor_idx_t  s1_addr_reg;
    logic [1:0]  s1_code_reg;
    logic [31:0] s1_steps_reg;
    logic [15:0] s1_speed_reg;

    // Flag state kept in flip-flops
    logic [NUM_MOTORS-1:0] reported_reg, reported_upd, reported_next;
    logic [NUM_MOTORS-1:0] zero_reg, zero_upd, zero_next;
    logic [NUM_MOTORS-1:0] stop_reg, stop_upd, stop_next;
    logic [NUM_MOTORS-1:0] ent_valid_reg;
    count_t edge_cnt_reg [NUM_MOTORS];
    count_t edge_cnt_upd [NUM_MOTORS];
    count_t period_reg   [NUM_MOTORS];
    count_t period_upd   [NUM_MOTORS];

    // Forwarding of the write made in the cycle of a read
    logic       fwd_valid_reg;
    motor_idx_t fwd_addr_reg;
    motor_rec_t fwd_data_reg;

    // RAM interface
    logic [REC_W-1:0] ram_rdata;
    logic             ram_we;
    motor_idx_t       rd_addr;

    // First stage decode
    motor_idx_t motor_idx;
    logic       motor_ok;
    hit_t       hit0;
    hit_t       hit1;

    // Second stage datapath
    motor_rec_t base;
    motor_rec_t rec_new;
    logic       wr;
    logic       done;

    // Result register
    logic        out_valid_reg;
    logic        out_motor_reg;
    logic [1:0]  dir_out_reg;
    logic        done_out_reg;
    logic        found_out_reg;
    logic [31:0] steps_out_reg;
    logic [15:0] cnt0_out_reg;
    logic [15:0] cnt1_out_reg;
    logic        stop0_out_reg;
    logic        stop1_out_reg;
    logic [15:0] target_out_reg;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    assign motor_idx = MOTOR_AW'(motor);
    assign motor_ok  = 32'(motor) < 32'(NUM_MOTORS);

    // The collect search sees the flags as they stand after the older transaction commits.
    assign hit0 = find_done(reported_next, zero_next);

    always_comb
    begin
        unique case (kind_t'(kind))
            KIND_COLLECT: rd_addr = hit0.idx;
            KIND_TICK:    rd_addr = '0;
            KIND_EDGE,
            KIND_MOVE:    rd_addr = motor_idx;
            default:      rd_addr = motor_idx;
        endcase
    end

    qmc_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_MOTORS),
        .AW    (MOTOR_AW)
    ) u_rec_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_addr_reg),
        .wdata (rec_new),
        .re    (in_fire),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign ram_we = s1_adv && wr;
    assign hit1   = find_done(reported_reg, zero_reg);

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            base = fwd_data_reg;
        end
        else if (ent_valid_reg[s1_addr_reg])
        begin
            base = motor_rec_t'(ram_rdata);
        end
        else
        begin
            base = '0;
        end
    end

    always_comb
    begin
        rec_new      = base;
        wr           = 1'b0;
        done         = 1'b0;
        reported_upd = reported_reg;
        zero_upd     = zero_reg;
        stop_upd     = stop_reg;
        edge_cnt_upd = edge_cnt_reg;
        period_upd   = period_reg;
        unique case (s1_kind_reg)
            KIND_EDGE:
            begin
                if (s1_ok_reg)
                begin
                    rec_new.code = s1_code_reg;
                    rec_new.dir  = step_class(base.code, s1_code_reg);
                    if (base.steps == 32'd1)
                    begin
                        rec_new.steps  = '0;
                        rec_new.target = '0;
                        reported_upd[s1_addr_reg] = 1'b0;
                        done = 1'b1;
                    end
                    else if (base.steps != '0)
                    begin
                        rec_new.steps = base.steps - 32'd1;
                    end
                    edge_cnt_upd[s1_addr_reg] = edge_cnt_reg[s1_addr_reg] + count_t'(1);
                    zero_upd[s1_addr_reg] = (rec_new.steps == '0);
                    stop_upd[s1_addr_reg] = (rec_new.target == '0);
                    wr = 1'b1;
                end
            end
            KIND_TICK:
            begin
                for (int i = 0; i < NUM_MOTORS; i++)
                begin
                    period_upd[i]   = edge_cnt_reg[i];
                    edge_cnt_upd[i] = '0;
                end
            end
            KIND_MOVE:
            begin
                if (s1_ok_reg)
                begin
                    rec_new.steps  = s1_steps_reg;
                    rec_new.target = s1_speed_reg;
                    reported_upd[s1_addr_reg] = 1'b1;
                    zero_upd[s1_addr_reg] = (s1_steps_reg == '0);
                    stop_upd[s1_addr_reg] = (s1_speed_reg == '0);
                    wr = 1'b1;
                end
            end
            KIND_COLLECT:
            begin
                if (hit1.found)
                begin
                    reported_upd[hit1.idx] = 1'b1;
                end
            end
            default:
            begin
                rec_new = base;
            end
        endcase
    end

    always_comb
    begin
        reported_next = s1_adv ? reported_upd : reported_reg;
        zero_next     = s1_adv ? zero_upd : zero_reg;
        stop_next     = s1_adv ? stop_upd : stop_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            reported_reg  <= '1;
            zero_reg      <= '1;
            stop_reg      <= '1;
            ent_valid_reg <= '0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                edge_cnt_reg[i] <= '0;
                period_reg[i]   <= '0;
            end
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire)
            begin
                fwd_valid_reg <= ram_we;
            end
            if (ram_we)
            begin
                ent_valid_reg[s1_addr_reg] <= 1'b1;
            end
            reported_reg <= reported_next;
            zero_reg     <= zero_next;
            stop_reg     <= stop_next;
            if (s1_adv)
            begin
                edge_cnt_reg <= edge_cnt_upd;
                period_reg   <= period_upd;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_kind_reg  <= kind_t'(kind);
            s1_motor_reg <= motor;
            s1_ok_reg    <= motor_ok || (kind_t'(kind) == KIND_TICK)
                            || (kind_t'(kind) == KIND_COLLECT);
            s1_addr_reg  <= rd_addr;
            s1_code_reg  <= {line_a, line_b};
            s1_steps_reg <= move_steps;
            s1_speed_reg <= speed_target;
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= rec_new;
        end
        if (s1_adv)
        begin
            unique case (s1_kind_reg)
                KIND_EDGE,
                KIND_MOVE:    out_motor_reg <= s1_motor_reg;
                KIND_TICK:    out_motor_reg <= 1'b0;
                KIND_COLLECT: out_motor_reg <= hit1.found ? hit1.idx[0] : 1'b0;
                default:      out_motor_reg <= 1'b0;
            endcase
            dir_out_reg    <= s1_ok_reg ? rec_new.dir : DIR_NONE;
            steps_out_reg  <= s1_ok_reg ? rec_new.steps : '0;
            target_out_reg <= s1_ok_reg ? rec_new.target : '0;
            done_out_reg   <= done;
            found_out_reg  <= (s1_kind_reg == KIND_COLLECT) && hit1.found;
            cnt0_out_reg   <= 16'(32'(period_upd[0]));
            cnt1_out_reg   <= (NUM_MOTORS > 1) ? 16'(32'(period_upd[SECOND_IDX])) : '0;
            stop0_out_reg  <= stop_upd[0];
            stop1_out_reg  <= (NUM_MOTORS > 1) ? stop_upd[SECOND_IDX] : 1'b1;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_motor      = out_motor_reg;
    assign direction_code = dir_out_reg;
    assign move_done      = done_out_reg;
    assign found          = found_out_reg;
    assign steps_left     = steps_out_reg;
    assign count_first    = cnt0_out_reg;
    assign count_second   = cnt1_out_reg;
    assign stop_first     = stop0_out_reg;
    assign stop_second    = stop1_out_reg;
    assign target_now     = target_out_reg;

`ifndef SYNTHESIS
    // A motor awaiting collection has a finished move and a cleared target speed.
    a_unreported_is_finished: assert property (@(posedge clk) disable iff (!rst_n)
        (~reported_reg & ~(zero_reg & stop_reg)) == '0)
        else $error("unreported motor without finished move");

    // A finishing edge leaves nothing to go and no target speed.
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && move_done |-> (steps_left == '0) && (target_now == '0))
        else $error("finished move with steps or speed left");

    // A collected motor has no steps left and is never also a finishing edge.
    a_found_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (steps_left == '0) && !move_done)
        else $error("collect result inconsistent");

    // The second stage keeps its transaction while the result register is blocked.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_addr_reg))
        else $error("second stage lost its transaction under stall");

    // The forwarded record is only used for a write made together with the read.
    a_fwd_only_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !ram_we |=> !fwd_valid_reg)
        else $error("forwarding enabled without a write");
`endif

endmodule

// ===== tb/quadrature_move_checker.sv =====
// Channel monitor, result predictor and scoreboard for the quadrature move counter.
module quadrature_move_checker
    import qmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  kind,
    input  logic        motor,
    input  logic        line_a,
    input  logic        line_b,
    input  logic [31:0] move_steps,
    input  logic [15:0] speed_target,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        out_motor,
    input  logic [1:0]  direction_code,
    input  logic        move_done,
    input  logic        found,
    input  logic [31:0] steps_left,
    input  logic [15:0] count_first,
    input  logic [15:0] count_second,
    input  logic        stop_first,
    input  logic        stop_second,
    input  logic [15:0] target_now,
    output int          error_count,
    output int          pending_count
);

    typedef struct packed {
        logic        motor_id;
        dir_t        dir;
        logic        done;
        logic        hit;
        logic [31:0] steps;
        logic [15:0] cnt0;
        logic [15:0] cnt1;
        logic        stop0;
        logic        stop1;
        logic [15:0] target;
    } motion_result_t;

    // Step class indexed by {previous code, new code}.
    localparam dir_t STEP_DIR_LUT [16] = '{
        DIR_NONE, DIR_REV,  DIR_FWD,  DIR_SKIP,
        DIR_FWD,  DIR_NONE, DIR_SKIP, DIR_REV,
        DIR_REV,  DIR_SKIP, DIR_NONE, DIR_FWD,
        DIR_SKIP, DIR_FWD,  DIR_REV,  DIR_NONE
    };

    logic [1:0]  prev_code     [NUM_MOTORS];
    logic [1:0]  cur_code      [NUM_MOTORS];
    dir_t        last_dir      [NUM_MOTORS];
    count_t      edges_seen    [NUM_MOTORS];
    count_t      period_edges  [NUM_MOTORS];
    logic [31:0] steps_to_go   [NUM_MOTORS];
    logic [15:0] speed_goal    [NUM_MOTORS];
    logic        reported      [NUM_MOTORS];

    motion_result_t expected_results [$];
    motion_result_t want_result;
    motion_result_t seen_result;
    int             errors = 0;

    function automatic motion_result_t predict_motion(input kind_t k, input logic m,
                                                      input logic a, input logic b,
                                                      input logic [31:0] steps,
                                                      input logic [15:0] speed);
        motion_result_t r;
        int             idx;
        int             subject;
        bit             in_range;
        bit             hit_found;
        logic [1:0]     code;
        r         = '0;
        idx       = int'(m);
        in_range  = idx < NUM_MOTORS;
        subject   = 0;
        hit_found = 1'b0;
        code      = {a, b};
        case (k)
            KIND_EDGE:
            begin
                if (in_range)
                begin
                    subject           = idx;
                    edges_seen[idx]   = edges_seen[idx] + 1'b1;
                    prev_code[idx]    = cur_code[idx];
                    cur_code[idx]     = code;
                    last_dir[idx]     = STEP_DIR_LUT[{prev_code[idx], code}];
                    if (steps_to_go[idx] == 32'd1)
                    begin
                        // The move has finished: it waits to be collected and the drive stops.
                        steps_to_go[idx] = '0;
                        reported[idx]    = 1'b0;
                        speed_goal[idx]  = '0;
                        r.done           = 1'b1;
                    end
                    else if (steps_to_go[idx] != '0)
                    begin
                        steps_to_go[idx] = steps_to_go[idx] - 32'd1;
                    end
                end
            end
            KIND_TICK:
            begin
                for (int i = 0; i < NUM_MOTORS; i++)
                begin
                    period_edges[i] = edges_seen[i];
                    edges_seen[i]   = '0;
                end
            end
            KIND_MOVE:
            begin
                if (in_range)
                begin
                    subject          = idx;
                    reported[idx]    = 1'b1;
                    steps_to_go[idx] = steps;
                    speed_goal[idx]  = speed;
                end
            end
            default:
            begin
                for (int i = 0; i < NUM_MOTORS; i++)
                begin
                    if (!hit_found && !reported[i] && steps_to_go[i] == '0)
                    begin
                        hit_found = 1'b1;
                        subject   = i;
                    end
                end
                if (hit_found)
                begin
                    reported[subject] = 1'b1;
                end
            end
        endcase
        r.motor_id = (k == KIND_EDGE || k == KIND_MOVE) ? m : subject[0];
        r.hit      = hit_found;
        if (in_range || k == KIND_TICK || k == KIND_COLLECT)
        begin
            r.dir    = last_dir[subject];
            r.steps  = steps_to_go[subject];
            r.target = speed_goal[subject];
        end
        r.cnt0  = period_edges[0];
        r.cnt1  = (NUM_MOTORS > 1) ? period_edges[SECOND_IDX] : '0;
        r.stop0 = (speed_goal[0] == '0);
        r.stop1 = (NUM_MOTORS > 1) ? (speed_goal[SECOND_IDX] == '0) : 1'b1;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [31:0] want,
                                 input logic [31:0] seen);
        if (seen !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, seen);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                prev_code[i]    = '0;
                cur_code[i]     = '0;
                last_dir[i]     = DIR_NONE;
                edges_seen[i]   = '0;
                period_edges[i] = '0;
                steps_to_go[i]  = '0;
                speed_goal[i]   = '0;
                reported[i]     = 1'b1;
            end
            expected_results.delete();
            error_count   <= errors;
            pending_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                seen_result = '{motor_id: out_motor, dir: dir_t'(direction_code),
                                done: move_done, hit: found, steps: steps_left,
                                cnt0: count_first, cnt1: count_second, stop0: stop_first,
                                stop1: stop_second, target: target_now};
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result transaction with nothing expected, actual %h",
                             $time, seen_result);
                    errors++;
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    compare_field("out_motor", want_result.motor_id, seen_result.motor_id);
                    compare_field("direction_code", want_result.dir, seen_result.dir);
                    compare_field("move_done", want_result.done, seen_result.done);
                    compare_field("found", want_result.hit, seen_result.hit);
                    compare_field("steps_left", want_result.steps, seen_result.steps);
                    compare_field("count_first", want_result.cnt0, seen_result.cnt0);
                    compare_field("count_second", want_result.cnt1, seen_result.cnt1);
                    compare_field("stop_first", want_result.stop0, seen_result.stop0);
                    compare_field("stop_second", want_result.stop1, seen_result.stop1);
                    compare_field("target_now", want_result.target, seen_result.target);
                end
            end
            if (in_valid && in_ready)
            begin
                expected_results.push_back(predict_motion(kind_t'(kind), motor, line_a, line_b,
                                                          move_steps, speed_target));
            end
            error_count   <= errors;
            pending_count <= expected_results.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the quadrature move counter testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
    import qmc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 300;
    localparam int RANDOM_ITEMS   = 720;
    localparam int BURST_EDGES    = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  kind;
    logic        motor;
    logic        line_a;
    logic        line_b;
    logic [31:0] move_steps;
    logic [15:0] speed_target;
    logic        out_valid;
    logic        out_ready;
    logic        out_motor;
    logic [1:0]  direction_code;
    logic        move_done;
    logic        found;
    logic [31:0] steps_left;
    logic [15:0] count_first;
    logic [15:0] count_second;
    logic        stop_first;
    logic        stop_second;
    logic [15:0] target_now;
    int          error_count;
    int          pending_count;

    bit tx_idle_on   = 1'b1;
    bit rx_idle_on   = 1'b1;
    bit hold_request = 1'b0;

    quadrature_move_counter DUT (.*);

    quadrature_move_checker scoreboard (.*);

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Mostly short gaps with the occasional long one.
    function automatic int idle_length();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    task automatic offer_transaction(input kind_t k, input logic m, input logic a,
                                     input logic b, input logic [31:0] steps,
                                     input logic [15:0] speed);
        int gap;
        gap = (tx_idle_on && $urandom_range(0, 3) == 0) ? idle_length() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= k;
        motor        <= m;
        line_a       <= a;
        line_b       <= b;
        move_steps   <= steps;
        speed_target <= speed;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
    endtask

    // Mostly move, edge and collect sequences with short step counts so that moves finish.
    task automatic offer_random_item();
        int          pick;
        kind_t       k;
        logic [31:0] steps;
        logic [15:0] speed;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            k = KIND_EDGE;
        else if (pick < 55)
            k = KIND_TICK;
        else if (pick < 75)
            k = KIND_MOVE;
        else
            k = KIND_COLLECT;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            steps = $urandom_range(1, 8);
        else if (pick < 8)
            steps = '0;
        else
            steps = $urandom();
        speed = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(0, 65535));
        offer_transaction(k, 1'($urandom()), 1'($urandom()), 1'($urandom()), steps, speed);
    endtask

    // Receiver: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        bit hold_taken;
        stall_left = 0;
        hold_taken = 1'b0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_taken)
            begin
                stall_left = LONG_HOLD;
                hold_taken = 1'b1;
            end
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (rx_idle_on && $urandom_range(0, 4) == 0)
                    stall_left = idle_length();
            end
        end
    end

    // Ends the run if no transaction moves on either channel for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("** quadrature_move_counter: FAILED **");
        $finish;
    end

    initial
    begin
        logic [1:0] walk_codes [16];
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        kind         = KIND_EDGE;
        motor        = 1'b0;
        line_a       = 1'b0;
        line_b       = 1'b0;
        move_steps   = '0;
        speed_target = '0;
        // Starting from code 0, this walk passes every previous/new code pair once.
        walk_codes = '{2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0,
                       2'd2, 2'd0, 2'd3, 2'd1, 2'd3, 2'd2, 2'd1, 2'd0};
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part.
        offer_transaction(KIND_COLLECT, 1'b0, 1'b0, 1'b0, '0, '0);
        offer_transaction(KIND_TICK, 1'b1, 1'b1, 1'b1, '1, '1);
        offer_transaction(KIND_MOVE, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF);
        offer_transaction(KIND_MOVE, 1'b1, 1'b1, 1'b1, 32'd0, 16'd0);
        foreach (walk_codes[i])
        begin
            offer_transaction(KIND_EDGE, 1'b0, walk_codes[i][1], walk_codes[i][0], '0, '0);
        end
        offer_transaction(KIND_TICK, 1'b0, 1'b0, 1'b0, '0, '0);
        offer_transaction(KIND_MOVE, 1'b1, 1'b0, 1'b0, 32'd1, 16'h1234);
        offer_transaction(KIND_EDGE, 1'b1, 1'b1, 1'b1, '0, '0);
        offer_transaction(KIND_COLLECT, 1'b0, 1'b0, 1'b0, '0, '0);
        offer_transaction(KIND_COLLECT, 1'b1, 1'b0, 1'b0, '0, '0);

        // A burst of edges on alternating motors at full rate, framed by ticks.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        offer_transaction(KIND_TICK, 1'b0, 1'b0, 1'b0, '0, '0);
        for (int i = 0; i < BURST_EDGES; i++)
        begin
            offer_transaction(KIND_EDGE, 1'(i), 1'($urandom()), 1'($urandom()), '0, '0);
        end
        offer_transaction(KIND_TICK, 1'b0, 1'b0, 1'b0, '0, '0);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        // Random part, with one long receiver hold-off and a stretch without idling.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 200)
            begin
                hold_request = 1'b1;
                tx_idle_on   = 1'b0;
            end
            if (i == 240)
                tx_idle_on = 1'b1;
            if (i == 400)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if (i == 500)
            begin
                tx_idle_on = 1'b1;
                rx_idle_on = 1'b1;
            end
            offer_random_item();
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (error_count == 0 && pending_count == 0)
            $display("** quadrature_move_counter: PASSED **");
        else
            $display("** quadrature_move_counter: FAILED **");
        $finish;
    end

endmodule
